[sv/chxy_pkg.sv]
// Shared types, widths and the arctangent table for the compass heading pipeline.
// Has no dependencies; every other file in this folder uses it.
package chxy_pkg;

	// Vector datapath: 16-bit sample scaled by 2^20 plus headroom for the CORDIC gain.
	localparam int IN_W     = 16;
	localparam int VEC_FRAC = 20;
	localparam int VEC_W    = 40;

	// Angle accumulator: signed degrees with 16 fraction bits.
	localparam int ANG_FRAC = 16;
	localparam int ANG_W    = 27;

	// Output format: degrees with 7 fraction bits.
	localparam int OUT_W    = 16;
	localparam int OUT_FRAC = 7;

	localparam int TABLE_LEN      = 24;
	localparam int ITERATIONS_DEF = 16;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * 65536);
	localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(360 * 65536);
	localparam logic signed [ANG_W-1:0] ROUND_HALF   =
		ANG_W'(1 << (ANG_FRAC - OUT_FRAC - 1));
	localparam logic [OUT_W-1:0]        OUT_FULL     = OUT_W'(46080);

	// Payload handed from one pipeline cell to the next.
	typedef struct packed {
		logic                    zero;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} vec_t;

	// atan(2^-i) in degrees times 2^16, rounded to nearest.
	function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			0:  r = ANG_W'(2949120);
			1:  r = ANG_W'(1740967);
			2:  r = ANG_W'(919879);
			3:  r = ANG_W'(466945);
			4:  r = ANG_W'(234379);
			5:  r = ANG_W'(117304);
			6:  r = ANG_W'(58666);
			7:  r = ANG_W'(29335);
			8:  r = ANG_W'(14668);
			9:  r = ANG_W'(7334);
			10: r = ANG_W'(3667);
			11: r = ANG_W'(1833);
			12: r = ANG_W'(917);
			13: r = ANG_W'(458);
			14: r = ANG_W'(229);
			15: r = ANG_W'(115);
			16: r = ANG_W'(57);
			17: r = ANG_W'(29);
			18: r = ANG_W'(14);
			19: r = ANG_W'(7);
			20: r = ANG_W'(4);
			21: r = ANG_W'(2);
			22: r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[sv/chxy_prerot.sv]
// Input stage: scales the sample pair and rotates it into the right half plane.
// Depends on chxy_pkg.
module chxy_prerot (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [chxy_pkg::IN_W-1:0]     field_x,
	input  logic signed [chxy_pkg::IN_W-1:0]     field_y,
	output logic                                 valid_s1,
	output chxy_pkg::vec_t                       vec_s1
);

	logic signed [chxy_pkg::VEC_W-1:0] sx, sy;
	chxy_pkg::vec_t                    nxt;

	// Sign-extend and scale by 2^20.
	assign sx = {{(chxy_pkg::VEC_W - chxy_pkg::IN_W - chxy_pkg::VEC_FRAC){field_x[chxy_pkg::IN_W-1]}},
		field_x, {chxy_pkg::VEC_FRAC{1'b0}}};
	assign sy = {{(chxy_pkg::VEC_W - chxy_pkg::IN_W - chxy_pkg::VEC_FRAC){field_y[chxy_pkg::IN_W-1]}},
		field_y, {chxy_pkg::VEC_FRAC{1'b0}}};

	// Quarter-turn pre-rotation; y = 0 on the negative x axis counts as upper half.
	always_comb begin
		nxt.zero = (field_x == '0) && (field_y == '0);
		nxt.x    = sx;
		nxt.y    = sy;
		nxt.z    = '0;
		if (sx < 0) begin
			if (sy >= 0) begin
				nxt.x = sy;
				nxt.y = -sx;
				nxt.z = chxy_pkg::QUARTER_TURN;
			end else begin
				nxt.x = -sy;
				nxt.y = sx;
				nxt.z = -chxy_pkg::QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= nxt;
	end

endmodule

[sv/chxy_cell.sv]
// One CORDIC vectoring micro-rotation with a fixed shift, registered at its output.
// Depends on chxy_pkg.
module chxy_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  chxy_pkg::vec_t vec_i,
	output logic           valid_s1,
	output chxy_pkg::vec_t vec_s1
);

	localparam logic signed [chxy_pkg::ANG_W-1:0] ANGLE = chxy_pkg::atan_deg(IDX);

	logic signed [chxy_pkg::VEC_W-1:0] xs, ys;
	chxy_pkg::vec_t                    nxt;

	// Arithmetic shifts are floor shifts on two's complement.
	assign xs = vec_i.x >>> IDX;
	assign ys = vec_i.y >>> IDX;

	// Rotate toward the x axis and track the angle.
	always_comb begin
		nxt.zero = vec_i.zero;
		if (vec_i.y > 0) begin
			nxt.x = vec_i.x + ys;
			nxt.y = vec_i.y - xs;
			nxt.z = vec_i.z + ANGLE;
		end else begin
			nxt.x = vec_i.x - ys;
			nxt.y = vec_i.y + xs;
			nxt.z = vec_i.z - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= nxt;
	end

endmodule

[sv/chxy_post.sv]
// Output stage: wraps the angle into one turn and rounds to 7 fraction bits.
// Depends on chxy_pkg.
module chxy_post (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_i,
	input  chxy_pkg::vec_t                 vec_i,
	output logic                           done_s1,
	output logic [chxy_pkg::OUT_W-1:0]     heading_s1
);

	logic signed [chxy_pkg::ANG_W-1:0] zw, zr;
	logic        [chxy_pkg::ANG_W-1:0] r;
	logic        [chxy_pkg::OUT_W-1:0] res;

	// Wrap negative angles, clamp, then round to the output grid.
	always_comb begin
		zw = vec_i.z;
		if (zw < 0) begin
			zw = zw + chxy_pkg::FULL_TURN;
		end
		if (zw < 0) begin
			zw = '0;
		end
		zr  = zw + chxy_pkg::ROUND_HALF;
		r   = chxy_pkg::ANG_W'(zr >>> (chxy_pkg::ANG_FRAC - chxy_pkg::OUT_FRAC));
		res = r[chxy_pkg::OUT_W-1:0];
		if (vec_i.zero || r >= chxy_pkg::ANG_W'(chxy_pkg::OUT_FULL)) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		heading_s1 <= res;
	end

endmodule

[sv/compass_heading_from_xy.sv]
// Compass heading atan2(y, x) in degrees from a signed x/y field sample.
// Stages in order: pre-rotation, one cell per micro-rotation (ITERATIONS, capped at TABLE_LEN), rounding.
// Throughput is one beat per cycle; busy is always low and every register stage moves
// each cycle, so the pipeline of CORDIC cells sets the latency and nothing stalls it.
// Reset clears only the valid bits; the result strobe done is low after reset.
// Depends on chxy_pkg, chxy_prerot, chxy_cell and chxy_post.
module compass_heading_from_xy #(
	parameter int ITERATIONS = chxy_pkg::ITERATIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [chxy_pkg::IN_W-1:0]   field_x,
	input  logic signed [chxy_pkg::IN_W-1:0]   field_y,
	output logic                               done,
	output logic        [chxy_pkg::OUT_W-1:0]  heading_deg
);

	localparam int N = (ITERATIONS < chxy_pkg::TABLE_LEN) ? ITERATIONS : chxy_pkg::TABLE_LEN;

	logic           valid_c [N+1];
	chxy_pkg::vec_t vec_c   [N+1];

	// The pipeline never stalls, so a beat is taken every cycle.
	assign busy = 1'b0;

	chxy_prerot u_prerot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.field_x  (field_x),
		.field_y  (field_y),
		.valid_s1 (valid_c[0]),
		.vec_s1   (vec_c[0])
	);

	// Chain of micro-rotation cells, shift index rising along the row.
	for (genvar i = 0; i < N; i++) begin : g_cell
		chxy_cell #(
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_i  (valid_c[i]),
			.vec_i    (vec_c[i]),
			.valid_s1 (valid_c[i+1]),
			.vec_s1   (vec_c[i+1])
		);
	end

	chxy_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_i    (valid_c[N]),
		.vec_i      (vec_c[N]),
		.done_s1    (done),
		.heading_s1 (heading_deg)
	);

endmodule
